[rtl/core/sfb_pkg.sv]
// Shared types and constants of the serial frame builder.
package sfb_pkg;

	localparam int MAX_PAYLOAD = 1024;
	localparam logic [15:0] FRAME_OVERHEAD = 16'd6;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	localparam logic REG_HEADER_FIRST = 1'b0;
	localparam logic REG_HEADER_SECOND = 1'b1;

	localparam logic [7:0] HEADER_FIRST_RESET = 8'hAA;
	localparam logic [7:0] HEADER_SECOND_RESET = 8'h55;

	localparam logic [2:0] SLOT_HDR0 = 3'd0;
	localparam logic [2:0] SLOT_HDR1 = 3'd1;
	localparam logic [2:0] SLOT_LEN_HI = 3'd2;
	localparam logic [2:0] SLOT_LEN_LO = 3'd3;
	localparam logic [2:0] SLOT_CODE = 3'd4;
	localparam logic [2:0] SLOT_SUM = 3'd5;
	localparam logic [2:0] SLOT_FIRST = 3'd0;
	localparam logic [2:0] SLOT_SECOND = 3'd1;

	typedef struct packed {
		logic        command;
		logic [7:0]  frame_code;
		logic [10:0] payload_length;
		logic [7:0]  data_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
	} out_word_t;

	typedef struct packed {
		logic       start;
		logic [7:0] first_byte;
		logic [7:0] len_hi;
		logic [7:0] len_lo;
		logic [7:0] sum;
		logic       with_sum;
	} job_t;

endpackage

[rtl/core/sfb_queue.sv]
// Small job queue between the front and back parts of the frame builder.
module sfb_queue
	import sfb_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head_job,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t q_mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign head_job = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/sfb_front.sv]
// Front part: accepts input words, tracks the open frame and queues byte jobs.
module sfb_front
	import sfb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_word_t in_data,
	input  logic     q_full,
	output logic     q_push,
	output job_t     q_job
);

	logic        frame_open_q;
	logic [10:0] remaining_q;
	logic [7:0]  sum_q;

	logic        accept;
	logic [10:0] plen_c;
	logic [15:0] total;
	logic [7:0]  start_sum;
	logic [7:0]  data_sum;
	logic [10:0] rem_next;
	logic        is_start;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign is_start = (in_data.command == CMD_START);

	always_comb begin
		if ({6'b0, in_data.payload_length} > 17'(MAX_PAYLOAD)) begin
			plen_c = 11'(MAX_PAYLOAD);
		end else begin
			plen_c = in_data.payload_length;
		end
		total = 16'(plen_c) + FRAME_OVERHEAD;
		start_sum = total[15:8] + total[7:0] + in_data.frame_code;
		data_sum = sum_q + in_data.data_byte;
		rem_next = (remaining_q == '0) ? '0 : remaining_q - 1'b1;
	end

	always_comb begin
		q_job.start = is_start;
		q_job.len_hi = total[15:8];
		q_job.len_lo = total[7:0];
		if (is_start) begin
			q_job.first_byte = in_data.frame_code;
			q_job.sum = start_sum;
			q_job.with_sum = (plen_c == '0);
		end else begin
			q_job.first_byte = in_data.data_byte;
			q_job.sum = data_sum;
			q_job.with_sum = (rem_next == '0);
		end
	end

	assign q_push = accept && (is_start || frame_open_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			remaining_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			if (is_start) begin
				if (plen_c == '0) begin
					frame_open_q <= 1'b0;
					remaining_q <= '0;
					sum_q <= '0;
				end else begin
					frame_open_q <= 1'b1;
					remaining_q <= plen_c;
					sum_q <= start_sum;
				end
			end else if (frame_open_q) begin
				remaining_q <= rem_next;
				if (rem_next == '0) begin
					frame_open_q <= 1'b0;
					sum_q <= '0;
				end else begin
					sum_q <= data_sum;
				end
			end
		end
	end

endmodule

[rtl/core/sfb_back.sv]
// Back part: plays queued jobs out as frame bytes into the output register.
module sfb_back
	import sfb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic [7:0] header_first,
	input  logic [7:0] header_second,
	input  job_t      head_job,
	input  logic      q_empty,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	out_word_t  out_data_q;

	logic       advance;
	logic [2:0] last_idx;
	logic [2:0] slot;
	logic       at_last;
	logic [7:0] sel_byte;

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign advance = !q_empty && (!out_valid_q || out_ready);

	always_comb begin
		if (head_job.start) begin
			last_idx = head_job.with_sum ? SLOT_SUM : SLOT_CODE;
			slot = idx_q;
		end else begin
			last_idx = head_job.with_sum ? SLOT_SECOND : SLOT_FIRST;
			slot = (idx_q == SLOT_FIRST) ? SLOT_CODE : SLOT_SUM;
		end
		at_last = (idx_q == last_idx);
	end

	always_comb begin
		unique case (slot)
			SLOT_HDR0:   sel_byte = header_first;
			SLOT_HDR1:   sel_byte = header_second;
			SLOT_LEN_HI: sel_byte = head_job.len_hi;
			SLOT_LEN_LO: sel_byte = head_job.len_lo;
			SLOT_CODE:   sel_byte = head_job.first_byte;
			SLOT_SUM:    sel_byte = head_job.sum;
			default:     sel_byte = '0;
		endcase
	end

	assign q_pop = advance && at_last;

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.out_byte <= sel_byte;
			out_data_q.run_last <= at_last;
			out_data_q.frame_end <= (slot == SLOT_SUM);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				idx_q <= at_last ? '0 : idx_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/serial_frame_builder_sum8.sv]
// Top level of the serial frame builder with header registers and APB port.
//
//   Channel  Direction  Handshake          Word
//   in       input      in_valid/in_ready  in_word_t (command, code, length, byte)
//   out      output     out_valid/out_ready out_word_t (byte, run_last, frame_end)
//   cfg      input      APB, pready high   header_first at 0x0, header_second at 0x4
//
// A start word produces five or six bytes, a data word inside a frame one or two and a data
// word outside a frame none; the bytes leave one per cycle while out_ready is high. A data
// word in steady flow is taken and sent on in every cycle while out_ready is high; the back
// part's byte sequencer sets the rate, so start and closing words hold the input only when
// the queue fills. An accepted word is written into the queue first and its first byte then
// into the output register; it waits longer while earlier bytes are still queued.
// Reset clears the frame state, the queue and the output valid flag, and restores the headers.
module serial_frame_builder_sum8
	import sfb_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] header_first_q;
	logic [7:0] header_second_q;
	logic       reg_sel;
	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_empty;
	job_t       push_job;
	job_t       head_job;

	assign pready = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q <= HEADER_FIRST_RESET;
			header_second_q <= HEADER_SECOND_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_HEADER_FIRST:  header_first_q <= pwdata[7:0];
				REG_HEADER_SECOND: header_second_q <= pwdata[7:0];
				default:           header_first_q <= header_first_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_HEADER_FIRST:  prdata = {24'b0, header_first_q};
			REG_HEADER_SECOND: prdata = {24'b0, header_second_q};
			default:           prdata = '0;
		endcase
	end

	sfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	sfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	sfb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.header_first  (header_first_q),
		.header_second (header_second_q),
		.head_job      (head_job),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data)
	);

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |-> out_data.run_last)
		else $error("checksum byte not marked as the last of its word");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job taken from an empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job written into a full queue");

	a_pop_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid && out_data.run_last)
		else $error("finished job did not leave a last byte in the output register");

endmodule
